### src/drsp_pkg.sv
// Shared types and codes for the dictionary record stream parser.
package drsp_pkg;

  typedef enum logic [1:0] {
    PH_KEY    = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2,
    PH_SKIP   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ORD_EQ = 2'd0,
    ORD_LT = 2'd1,
    ORD_GT = 2'd2
  } order_e;

  typedef enum logic [1:0] {
    KIND_CELL   = 2'd0,
    KIND_RECORD = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ERR_UNTERMINATED = 4'd0,
    ERR_EMPTY_RECORD = 4'd1,
    ERR_EMPTY_KEY    = 4'd2,
    ERR_KEY_LONG     = 4'd3,
    ERR_NO_ENDING    = 4'd4,
    ERR_BAD_ENDING   = 4'd5,
    ERR_CAND_LIMIT   = 4'd6,
    ERR_BAD_FIRST    = 4'd7,
    ERR_PARTIAL_PAIR = 4'd8,
    ERR_BAD_SECOND   = 4'd9,
    ERR_CELL_LIMIT   = 4'd10,
    ERR_UNSORTED     = 4'd11,
    ERR_RECORD_LIMIT = 4'd12,
    ERR_TOO_LARGE    = 4'd13
  } err_e;

  localparam logic [7:0] CH_LF        = 8'h0a;
  localparam logic [7:0] CH_SLASH     = 8'h2f;
  localparam logic [7:0] CH_PRINT_LO  = 8'h21;
  localparam logic [7:0] CH_PRINT_HI  = 8'h7e;

  typedef struct packed {
    kind_e       kind;
    logic [14:0] cell_code;
    logic [25:0] record_start;
    logic [4:0]  key_length;
    logic [6:0]  ending_char;
    logic [16:0] record_candidates;
    logic [16:0] record_cells;
    err_e        error_code;
    logic [25:0] error_offset;
    logic        is_final;
  } result_t;

endpackage

### src/drsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module drsp_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### src/drsp_core.sv
// Parser state and the per-byte step logic; holds the two key banks in a RAM.
module drsp_core #(
  parameter int MAX_KEY_BYTES  = 16,
  parameter int MAX_CANDIDATES = 65536,
  parameter int MAX_CELLS      = 65536,
  parameter int MAX_RECORDS    = 65536,
  parameter int MAX_DATA_BYTES = 67108864
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  output logic              res_valid_o,
  output drsp_pkg::result_t res_o
);

  localparam int LW = $clog2(MAX_KEY_BYTES + 1);
  localparam int KW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int AW = KW + 1;
  localparam int CW = $clog2(MAX_CANDIDATES + 1);
  localparam int EW = $clog2(MAX_CELLS + 1);
  localparam int RW = $clog2(MAX_RECORDS + 1);
  localparam int OW = $clog2(MAX_DATA_BYTES);
  localparam int BW = $clog2(MAX_DATA_BYTES + 1);

  drsp_pkg::phase_e phase_q, phase_d;
  drsp_pkg::order_e order_q, order_d;
  logic [BW-1:0] off_q, off_d;
  logic [OW-1:0] ls_q, ls_d;
  logic          bank_q, bank_d;
  logic [LW-1:0] len_q, len_d, plen_q, plen_d;
  logic          hprev_q, hprev_d, open_q, open_d, halt_q, halt_d;
  logic [6:0]    first_q, first_d, end_q, end_d;
  drsp_pkg::err_e lerr_q, lerr_d;
  logic          lerrv_q, lerrv_d;
  logic [OW-1:0] lerro_q, lerro_d;
  logic [CW-1:0] tcand_q, tcand_d, lcand_q, lcand_d;
  logic [EW-1:0] tcell_q, tcell_d, lcell_q, lcell_d;
  logic [RW-1:0] trec_q, trec_d;

  logic          key_we;
  logic [7:0]    prev_byte;
  logic [OW-1:0] off_w;

  drsp_ram #(.Width(8), .Depth(2 ** AW)) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .waddr_i({bank_q, len_q[KW-1:0]}),
    .wdata_i(byte_i),
    .raddr_i({~bank_d, len_d[KW-1:0]}),
    .rdata_o(prev_byte)
  );

  assign off_w = off_q[OW-1:0];

  always_comb begin
    phase_d = phase_q; order_d = order_q; off_d = off_q; ls_d = ls_q;
    bank_d = bank_q; len_d = len_q; plen_d = plen_q; hprev_d = hprev_q;
    open_d = open_q; halt_d = halt_q; first_d = first_q; end_d = end_q;
    lerr_d = lerr_q; lerrv_d = lerrv_q; lerro_d = lerro_q;
    tcand_d = tcand_q; lcand_d = lcand_q; tcell_d = tcell_q; lcell_d = lcell_q;
    trec_d = trec_q;
    key_we = 1'b0;
    res_valid_o = 1'b0;
    res_o = '0;

    if (step_i && !halt_q) begin
      if (off_q == BW'(MAX_DATA_BYTES)) begin
        res_valid_o = 1'b1;
        res_o.kind = drsp_pkg::KIND_ERROR;
        res_o.error_code = drsp_pkg::ERR_TOO_LARGE;
        res_o.error_offset = 26'(MAX_DATA_BYTES - 1);
      end else begin
        off_d = off_q + BW'(1);
        if (last_i && byte_i != drsp_pkg::CH_LF) begin
          res_valid_o = 1'b1;
          res_o.kind = drsp_pkg::KIND_ERROR;
          res_o.error_code = drsp_pkg::ERR_UNTERMINATED;
          res_o.error_offset = 26'(ls_q);
        end else if (byte_i == drsp_pkg::CH_LF) begin
          res_valid_o = 1'b1;
          res_o.kind = drsp_pkg::KIND_ERROR;
          if (lerrv_q) begin
            res_o.error_code = lerr_q;
            res_o.error_offset = 26'(lerro_q);
          end else if (phase_q == drsp_pkg::PH_KEY) begin
            if (len_q == '0) begin
              res_o.error_code = drsp_pkg::ERR_EMPTY_RECORD;
              res_o.error_offset = 26'(ls_q);
            end else begin
              res_o.error_code = drsp_pkg::ERR_NO_ENDING;
              res_o.error_offset = 26'(off_w);
            end
          end else if (phase_q == drsp_pkg::PH_SECOND) begin
            res_o.error_code = drsp_pkg::ERR_PARTIAL_PAIR;
            res_o.error_offset = 26'(off_w - OW'(1));
          end else if (hprev_q && (order_q == drsp_pkg::ORD_LT ||
                       (order_q == drsp_pkg::ORD_EQ && len_q < plen_q))) begin
            res_o.error_code = drsp_pkg::ERR_UNSORTED;
            res_o.error_offset = 26'(ls_q);
          end else if (trec_q == RW'(MAX_RECORDS)) begin
            res_o.error_code = drsp_pkg::ERR_RECORD_LIMIT;
            res_o.error_offset = 26'(ls_q);
          end else begin
            res_o.kind = drsp_pkg::KIND_RECORD;
            res_o.record_start = 26'(ls_q);
            res_o.key_length = 5'(len_q);
            res_o.ending_char = end_q;
            res_o.record_candidates = 17'(lcand_q);
            res_o.record_cells = 17'(lcell_q);
            trec_d = trec_q + RW'(1);
            plen_d = len_q;
            hprev_d = 1'b1;
            bank_d = ~bank_q;
          end
          res_o.is_final = (res_o.kind == drsp_pkg::KIND_ERROR) || last_i;
          halt_d = res_o.is_final;
          // start the next line
          ls_d = off_w + OW'(1);
          phase_d = drsp_pkg::PH_KEY;
          len_d = '0;
          order_d = drsp_pkg::ORD_EQ;
          open_d = 1'b0;
          first_d = '0;
          lerrv_d = 1'b0;
          lerr_d = drsp_pkg::ERR_UNTERMINATED;
          lerro_d = '0;
          lcand_d = '0;
          lcell_d = '0;
        end else begin
          unique case (phase_q)
            drsp_pkg::PH_KEY: begin
              if (byte_i[7]) begin
                if (len_q >= LW'(MAX_KEY_BYTES)) begin
                  lerrv_d = 1'b1; lerr_d = drsp_pkg::ERR_KEY_LONG; lerro_d = ls_q;
                  phase_d = drsp_pkg::PH_SKIP;
                end else begin
                  if (hprev_q && order_q == drsp_pkg::ORD_EQ) begin
                    if (len_q < plen_q) begin
                      if (byte_i < prev_byte) order_d = drsp_pkg::ORD_LT;
                      else if (byte_i > prev_byte) order_d = drsp_pkg::ORD_GT;
                    end else begin
                      order_d = drsp_pkg::ORD_GT;
                    end
                  end
                  key_we = 1'b1;
                  len_d = len_q + LW'(1);
                end
              end else if (len_q == '0) begin
                lerrv_d = 1'b1; lerr_d = drsp_pkg::ERR_EMPTY_KEY; lerro_d = ls_q;
                phase_d = drsp_pkg::PH_SKIP;
              end else if (byte_i < drsp_pkg::CH_PRINT_LO ||
                           byte_i > drsp_pkg::CH_PRINT_HI) begin
                lerrv_d = 1'b1; lerr_d = drsp_pkg::ERR_BAD_ENDING; lerro_d = off_w;
                phase_d = drsp_pkg::PH_SKIP;
              end else begin
                end_d = byte_i[6:0];
                phase_d = drsp_pkg::PH_FIRST;
                open_d = 1'b1;
              end
            end
            drsp_pkg::PH_FIRST: begin
              if (open_q && tcand_q == CW'(MAX_CANDIDATES)) begin
                lerrv_d = 1'b1; lerr_d = drsp_pkg::ERR_CAND_LIMIT; lerro_d = off_w;
                phase_d = drsp_pkg::PH_SKIP;
              end else begin
                if (open_q) begin
                  tcand_d = tcand_q + CW'(1);
                  lcand_d = lcand_q + CW'(1);
                end
                open_d = (byte_i == drsp_pkg::CH_SLASH);
                if (byte_i == drsp_pkg::CH_SLASH) begin
                  phase_d = drsp_pkg::PH_FIRST;
                end else if (byte_i[7]) begin
                  first_d = byte_i[6:0];
                  phase_d = drsp_pkg::PH_SECOND;
                end else begin
                  lerrv_d = 1'b1; lerr_d = drsp_pkg::ERR_BAD_FIRST; lerro_d = off_w;
                  phase_d = drsp_pkg::PH_SKIP;
                end
              end
            end
            drsp_pkg::PH_SECOND: begin
              if (!byte_i[7]) begin
                lerrv_d = 1'b1; lerr_d = drsp_pkg::ERR_BAD_SECOND; lerro_d = off_w;
                phase_d = drsp_pkg::PH_SKIP;
              end else if (tcell_q == EW'(MAX_CELLS)) begin
                lerrv_d = 1'b1; lerr_d = drsp_pkg::ERR_CELL_LIMIT;
                lerro_d = off_w - OW'(1);
                phase_d = drsp_pkg::PH_SKIP;
              end else begin
                tcell_d = tcell_q + EW'(1);
                lcell_d = lcell_q + EW'(1);
                phase_d = drsp_pkg::PH_FIRST;
                res_valid_o = 1'b1;
                res_o.kind = drsp_pkg::KIND_CELL;
                // first half in bits 14:8, bit 7 stays clear
                res_o.cell_code = {first_q, 1'b0, byte_i[6:0]};
              end
            end
            default: begin
              phase_d = drsp_pkg::PH_SKIP;
            end
          endcase
        end
      end
      if (res_valid_o && res_o.kind == drsp_pkg::KIND_ERROR) begin
        res_o.is_final = 1'b1;
        halt_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= drsp_pkg::PH_KEY; order_q <= drsp_pkg::ORD_EQ;
      off_q <= '0; ls_q <= '0; bank_q <= 1'b0; len_q <= '0; plen_q <= '0;
      hprev_q <= 1'b0; open_q <= 1'b0; halt_q <= 1'b0;
      first_q <= '0; end_q <= '0;
      lerr_q <= drsp_pkg::ERR_UNTERMINATED; lerrv_q <= 1'b0; lerro_q <= '0;
      tcand_q <= '0; lcand_q <= '0; tcell_q <= '0; lcell_q <= '0; trec_q <= '0;
    end else begin
      phase_q <= phase_d; order_q <= order_d;
      off_q <= off_d; ls_q <= ls_d; bank_q <= bank_d; len_q <= len_d; plen_q <= plen_d;
      hprev_q <= hprev_d; open_q <= open_d; halt_q <= halt_d;
      first_q <= first_d; end_q <= end_d;
      lerr_q <= lerr_d; lerrv_q <= lerrv_d; lerro_q <= lerro_d;
      tcand_q <= tcand_d; lcand_q <= lcand_d; tcell_q <= tcell_d; lcell_q <= lcell_d;
      trec_q <= trec_d;
    end
  end

endmodule

### src/dictionary_record_stream_parser_top.sv
// Top level: input register, parser core and result register.
//
//  channel  | dir | tdata (low bit up)                               | tlast    | tuser
//  s_axis   | in  | data_byte[7:0]                                   | is_last  | -
//  m_axis   | out | cell_code, record_start, key_length, ending_char,| is_final | kind
//           |     | record_candidates, record_cells, error_code,     |          |
//           |     | error_offset (117 bits, zero filled to 120)      |          |
//
// One byte per cycle unless m_axis stalls; each byte and its result are registered.
// The rate is set by the key RAM read, which is addressed from next state.
// Reset clears all control state; the key RAM holds no reset value.
// A stall on m_axis holds the input register and then s_axis_tready.
module dictionary_record_stream_parser_top #(
  parameter int MAX_KEY_BYTES  = 16,
  parameter int MAX_CANDIDATES = 65536,
  parameter int MAX_CELLS      = 65536,
  parameter int MAX_RECORDS    = 65536,
  parameter int MAX_DATA_BYTES = 67108864
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // data_byte
  input  logic         s_axis_tlast,   // is_last
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // cell_code, record_start, key_length, ending_char, record_candidates,
  // record_cells, error_code, error_offset, zero fill
  output logic [119:0] m_axis_tdata,
  output logic         m_axis_tlast,   // is_final
  output logic [1:0]   m_axis_tuser    // kind
);

  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              in_last_q;
  logic              advance;
  logic              res_valid;
  drsp_pkg::result_t res, out_q;
  logic              out_valid_q;

  assign advance = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  drsp_core #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES),
    .MAX_CANDIDATES(MAX_CANDIDATES),
    .MAX_CELLS     (MAX_CELLS),
    .MAX_RECORDS   (MAX_RECORDS),
    .MAX_DATA_BYTES(MAX_DATA_BYTES)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .byte_i     (in_byte_q),
    .last_i     (in_last_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= advance && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_q.is_final;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {3'b000, out_q.error_offset, out_q.error_code,
                          out_q.record_cells, out_q.record_candidates,
                          out_q.ending_char, out_q.key_length,
                          out_q.record_start, out_q.cell_code};

  // nothing follows the closing result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
    else $error("result after final transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == drsp_pkg::KIND_ERROR |-> m_axis_tlast)
    else $error("error result not marked final");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == drsp_pkg::KIND_CELL |->
      m_axis_tdata[119:15] == '0 && !m_axis_tlast)
    else $error("cell result carries record or error fields");

endmodule

### tb/sv/drsp_checker.sv
// Checker: predicts parser results from accepted bytes and compares them.
module drsp_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,
  input  logic         s_axis_tlast,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [119:0] m_axis_tdata,
  input  logic         m_axis_tlast,
  input  logic [1:0]   m_axis_tuser,
  output int           fail_count,
  output int           pending
);

  localparam int KEY_MAX   = 16;
  localparam int CAND_MAX  = 65536;
  localparam int CELL_MAX  = 65536;
  localparam int REC_MAX   = 65536;
  localparam int BYTES_MAX = 67108864;

  drsp_pkg::result_t expected_q[$];

  drsp_pkg::phase_e ph;
  drsp_pkg::order_e order;
  int unsigned offset, rec_start, key_len, prev_key_len, bank;
  logic [7:0]  keys [2][KEY_MAX];
  bit          have_prev, open_pending, halted, err_valid;
  logic [6:0]  first_half, ending;
  drsp_pkg::err_e err_code;
  int unsigned err_off;
  int unsigned tot_cand, tot_cells, tot_recs, line_cand, line_cells;

  function automatic drsp_pkg::result_t error_result(drsp_pkg::err_e code,
                                                     int unsigned off);
    drsp_pkg::result_t r;
    r = '0;
    r.kind = drsp_pkg::KIND_ERROR;
    r.error_code = code;
    r.error_offset = off[25:0];
    r.is_final = 1'b1;
    halted = 1'b1;
    return r;
  endfunction

  function automatic void hold(drsp_pkg::err_e code, int unsigned off);
    if (!err_valid) begin
      err_code = code;
      err_off = off;
      err_valid = 1'b1;
    end
    ph = drsp_pkg::PH_SKIP;
  endfunction

  function automatic void open_line(int unsigned start);
    rec_start = start;
    ph = drsp_pkg::PH_KEY;
    key_len = 0;
    order = drsp_pkg::ORD_EQ;
    open_pending = 0;
    first_half = '0;
    err_valid = 0;
    line_cand = 0;
    line_cells = 0;
  endfunction

  function automatic void clear_state();
    offset = 0;
    bank = 0;
    prev_key_len = 0;
    have_prev = 0;
    ending = '0;
    tot_cand = 0;
    tot_cells = 0;
    tot_recs = 0;
    halted = 0;
    open_line(0);
  endfunction

  function automatic drsp_pkg::result_t close_line(int unsigned off, bit last);
    drsp_pkg::result_t r;
    r = '0;
    if (err_valid) r = error_result(err_code, err_off);
    else if (ph == drsp_pkg::PH_KEY) begin
      if (key_len == 0) r = error_result(drsp_pkg::ERR_EMPTY_RECORD, rec_start);
      else r = error_result(drsp_pkg::ERR_NO_ENDING, off);
    end else if (ph == drsp_pkg::PH_SECOND)
      r = error_result(drsp_pkg::ERR_PARTIAL_PAIR, off - 1);
    else if (have_prev && (order == drsp_pkg::ORD_LT ||
             (order == drsp_pkg::ORD_EQ && key_len < prev_key_len)))
      r = error_result(drsp_pkg::ERR_UNSORTED, rec_start);
    else if (tot_recs == REC_MAX)
      r = error_result(drsp_pkg::ERR_RECORD_LIMIT, rec_start);
    else begin
      r.kind = drsp_pkg::KIND_RECORD;
      r.record_start = rec_start[25:0];
      r.key_length = key_len[4:0];
      r.ending_char = ending;
      r.record_candidates = line_cand[16:0];
      r.record_cells = line_cells[16:0];
      r.is_final = last;
      if (last) halted = 1'b1;
      tot_recs++;
      prev_key_len = key_len;
      have_prev = 1'b1;
      bank ^= 1;
    end
    open_line(off + 1);
    return r;
  endfunction

  // Returns 1 when the byte produces a result.
  function automatic bit parse_byte(logic [7:0] b, bit last,
                                    output drsp_pkg::result_t r);
    int unsigned off;
    r = '0;
    off = offset;
    if (halted) return 0;
    if (off >= BYTES_MAX) begin
      r = error_result(drsp_pkg::ERR_TOO_LARGE, BYTES_MAX - 1);
      return 1;
    end
    offset = off + 1;
    if (last && b != drsp_pkg::CH_LF) begin
      r = error_result(drsp_pkg::ERR_UNTERMINATED, rec_start);
      return 1;
    end
    if (b == drsp_pkg::CH_LF) begin
      r = close_line(off, last);
      return 1;
    end
    case (ph)
      drsp_pkg::PH_KEY: begin
        if (b[7]) begin
          if (key_len >= KEY_MAX) hold(drsp_pkg::ERR_KEY_LONG, rec_start);
          else begin
            if (have_prev && order == drsp_pkg::ORD_EQ) begin
              if (key_len < prev_key_len) begin
                if (b < keys[bank ^ 1][key_len]) order = drsp_pkg::ORD_LT;
                else if (b > keys[bank ^ 1][key_len]) order = drsp_pkg::ORD_GT;
              end else order = drsp_pkg::ORD_GT;
            end
            keys[bank][key_len] = b;
            key_len++;
          end
        end else if (key_len == 0) hold(drsp_pkg::ERR_EMPTY_KEY, rec_start);
        else if (b < drsp_pkg::CH_PRINT_LO || b > drsp_pkg::CH_PRINT_HI)
          hold(drsp_pkg::ERR_BAD_ENDING, off);
        else begin
          ending = b[6:0];
          ph = drsp_pkg::PH_FIRST;
          open_pending = 1;
        end
      end
      drsp_pkg::PH_FIRST: begin
        if (open_pending) begin
          if (tot_cand == CAND_MAX) begin
            hold(drsp_pkg::ERR_CAND_LIMIT, off);
            return 0;
          end
          tot_cand++;
          line_cand++;
          open_pending = 0;
        end
        if (b == drsp_pkg::CH_SLASH) open_pending = 1;
        else if (b[7]) begin
          first_half = b[6:0];
          ph = drsp_pkg::PH_SECOND;
        end else hold(drsp_pkg::ERR_BAD_FIRST, off);
      end
      drsp_pkg::PH_SECOND: begin
        if (!b[7]) hold(drsp_pkg::ERR_BAD_SECOND, off);
        else if (tot_cells == CELL_MAX) hold(drsp_pkg::ERR_CELL_LIMIT, off - 1);
        else begin
          tot_cells++;
          line_cells++;
          ph = drsp_pkg::PH_FIRST;
          r.kind = drsp_pkg::KIND_CELL;
          r.cell_code = {first_half, 1'b0, b[6:0]};
          return 1;
        end
      end
      default: ;
    endcase
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    drsp_pkg::result_t exp_r, got;
    if (!rst_ni) begin
      clear_state();
      expected_q.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '0;
        got.kind = drsp_pkg::kind_e'(m_axis_tuser);
        got.cell_code = m_axis_tdata[14:0];
        got.record_start = m_axis_tdata[40:15];
        got.key_length = m_axis_tdata[45:41];
        got.ending_char = m_axis_tdata[52:46];
        got.record_candidates = m_axis_tdata[69:53];
        got.record_cells = m_axis_tdata[86:70];
        got.error_code = drsp_pkg::err_e'(m_axis_tdata[90:87]);
        got.error_offset = m_axis_tdata[116:91];
        got.is_final = m_axis_tlast;
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r || m_axis_tdata[119:117] !== 3'b0) begin
            if (fail_count < 10)
              $display("mismatch: expected %p actual %p", exp_r, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (parse_byte(s_axis_tdata, s_axis_tlast, exp_r)) expected_q = {expected_q, exp_r};
      end
      pending <= expected_q.size();
    end
  end

endmodule

### tb/sv/testbench.sv
// Testbench top: byte stimulus, receiver stalls, watchdog and verdict.
module testbench;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [119:0] m_axis_tdata;
  logic         m_axis_tlast;
  logic [1:0]   m_axis_tuser;
  int           fail_count, pending;
  int           idle_cycles = 0;
  int           sent = 0;
  bit           no_gaps = 0;
  logic [7:0]   prev_key[$];

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  dictionary_record_stream_parser_top dut (.*);

  drsp_checker checker_i (.*);

  // Watchdog: end the run after a long stretch with no transaction.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: a long hold-off early on, then random stalls.
  initial begin
    int g;
    @(posedge rst_ni);
    repeat (30) @(posedge clk_i);
    m_axis_tready <= 1'b0;
    repeat (400) @(posedge clk_i);
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      g = gap_len();
      if (g > 0) begin
        m_axis_tready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
  end

  task automatic send(logic [7:0] b, bit last = 0);
    int g;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
    if (sent % 64 == 0) no_gaps = ($urandom_range(0, 3) == 0);
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  function automatic logic [7:0] hi_byte();
    return 8'h80 | 8'($urandom_range(0, 127));
  endfunction

  // Build a key that sorts at or above the previous one.
  task automatic send_sorted_key();
    logic [7:0] k[$];
    int p, n;
    p = $urandom_range(0, prev_key.size());
    // no byte sorts above 0xff there: keep the whole previous key instead
    if (p < prev_key.size() && prev_key[p] == 8'hff) p = prev_key.size();
    for (int i = 0; i < p; i++) k = {k, prev_key[i]};
    if (p < prev_key.size() && prev_key[p] != 8'hff)
      k = {k, 8'($urandom_range(prev_key[p] + 1, 255))};
    n = $urandom_range(0, 3);
    while (n-- > 0 && k.size() < 16) k = {k, hi_byte()};
    if (k.size() == 0) k = {k, hi_byte()};
    if (k.size() < prev_key.size() && p == k.size()) k = prev_key;
    if ($urandom_range(0, 29) == 0) begin
      k.delete();
      for (int i = 0; i < 16; i++) k = {k, 8'hff};
      if (prev_key.size() == 16 && prev_key[15] != 8'hff) k = prev_key;
      k[0] = 8'hff;
    end
    prev_key = k;
    foreach (k[i]) send(k[i]);
  endtask

  task automatic send_body();
    int nc;
    send(8'($urandom_range(8'h21, 8'h7e)));
    nc = $urandom_range(0, 3);
    for (int c = 0; c < nc; c++) begin
      if (c > 0 || $urandom_range(0, 3) == 0) send(drsp_pkg::CH_SLASH);
      repeat ($urandom_range(0, 4)) begin
        send(hi_byte());
        send(hi_byte());
      end
    end
  endtask

  task automatic send_record(bit last = 0);
    send_sorted_key();
    send_body();
    send(drsp_pkg::CH_LF, last);
  endtask

  // Junk that a held error skips over up to the LF.
  task automatic send_junk();
    logic [7:0] b;
    repeat ($urandom_range(0, 4)) begin
      b = 8'($urandom_range(0, 255));
      send(b == drsp_pkg::CH_LF ? 8'h00 : b);
    end
  endtask

  task automatic send_closing_case();
    case ($urandom_range(0, 10))
      0: send_record(1);
      1: send(drsp_pkg::CH_LF);
      2: begin
        send(8'($urandom_range(8'h00, 8'h7f) == drsp_pkg::CH_LF ? 8'h41 : 8'h41));
        send_junk();
        send(drsp_pkg::CH_LF);
      end
      3: begin
        repeat (17) send(8'hff);
        send_junk();
        send(drsp_pkg::CH_LF);
      end
      4: begin
        send_sorted_key();
        send(drsp_pkg::CH_LF);
      end
      5: begin
        send_sorted_key();
        send($urandom_range(0, 1) ? 8'h20 : 8'h7f);
        send_junk();
        send(drsp_pkg::CH_LF);
      end
      6: begin
        send_sorted_key();
        send(8'h2a);
        send(8'($urandom_range(0, 1) ? 8'h00 : 8'h7f));
        send_junk();
        send(drsp_pkg::CH_LF);
      end
      7: begin
        send_sorted_key();
        send(8'h2a);
        send(hi_byte());
        send(drsp_pkg::CH_LF);
      end
      8: begin
        send_sorted_key();
        send(8'h2a);
        send(hi_byte());
        send(8'($urandom_range(0, 127) == drsp_pkg::CH_LF ? 8'h01 : 8'h55));
        send_junk();
        send(drsp_pkg::CH_LF);
      end
      9: begin
        // Unsorted: a proper prefix of the previous key, or a lower byte; else an empty record.
        if (prev_key.size() > 1) begin
          for (int i = 0; i < prev_key.size() - 1; i++) send(prev_key[i]);
        end else if (prev_key.size() == 1 && prev_key[0] > 8'h80) begin
          send(prev_key[0] - 8'd1);
        end else send(drsp_pkg::CH_LF);
        send(8'h2a);
        send(drsp_pkg::CH_LF);
      end
      default: begin
        send_sorted_key();
        send_junk();
        send(8'($urandom_range(0, 255)) == drsp_pkg::CH_LF ? 8'h00 : 8'h33, 1);
      end
    endcase
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: short and long keys, equal keys, empty bodies, slashes.
    send(8'h80); send(8'h21); send(drsp_pkg::CH_LF);
    prev_key = '{8'h80};
    send(8'h80); send(8'h7e); send(drsp_pkg::CH_SLASH); send(drsp_pkg::CH_SLASH);
    send(8'hff); send(8'h80); send(drsp_pkg::CH_LF);
    for (int i = 0; i < 16; i++) send(8'h80 + 8'(i));
    send(8'h7e); send(8'h80); send(8'hff); send(drsp_pkg::CH_LF);
    prev_key.delete();
    for (int i = 0; i < 16; i++) prev_key = {prev_key, 8'(8'h80 + 8'(i))};
    while (sent < 540) send_record();
    send_closing_case();
    // Halted: these bytes are accepted and produce nothing.
    repeat ($urandom_range(2, 6)) send(8'($urandom_range(0, 255)), $urandom_range(0, 1));
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule
